// ===== sv/hpack_huffman_decoder_assert.svh =====
`ifndef HPACK_HUFFMAN_DECODER_ASSERT_SVH
`define HPACK_HUFFMAN_DECODER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define HHD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hpack huffman decoder check failed");

// Next-cycle implication, checked while out of reset.
`define HHD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hpack huffman decoder check failed");

`endif

// ===== sv/hhd_pkg.sv =====
package hhd_pkg;

	typedef enum logic [1:0] {
		KIND_SYM = 2'd0,
		KIND_ERR = 2'd1,
		KIND_END = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_in_string;
	} in_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] symbol;
		logic       last_of_run;
	} out_t;

	typedef struct packed {
		logic [29:0] pat;
		logic [4:0]  len;
	} code_t;

	typedef logic [255:0][1:0][8:0] tree_t;

	localparam code_t CODES [256] = '{
		'{30'h1ff8,5'd13},'{30'h7fffd8,5'd23},'{30'hfffffe2,5'd28},'{30'hfffffe3,5'd28},
		'{30'hfffffe4,5'd28},'{30'hfffffe5,5'd28},'{30'hfffffe6,5'd28},'{30'hfffffe7,5'd28},
		'{30'hfffffe8,5'd28},'{30'hffffea,5'd24},'{30'h3ffffffc,5'd30},'{30'hfffffe9,5'd28},
		'{30'hfffffea,5'd28},'{30'h3ffffffd,5'd30},'{30'hfffffeb,5'd28},'{30'hfffffec,5'd28},
		'{30'hfffffed,5'd28},'{30'hfffffee,5'd28},'{30'hfffffef,5'd28},'{30'hffffff0,5'd28},
		'{30'hffffff1,5'd28},'{30'hffffff2,5'd28},'{30'h3ffffffe,5'd30},'{30'hffffff3,5'd28},
		'{30'hffffff4,5'd28},'{30'hffffff5,5'd28},'{30'hffffff6,5'd28},'{30'hffffff7,5'd28},
		'{30'hffffff8,5'd28},'{30'hffffff9,5'd28},'{30'hffffffa,5'd28},'{30'hffffffb,5'd28},
		'{30'h14,5'd6},'{30'h3f8,5'd10},'{30'h3f9,5'd10},'{30'hffa,5'd12},
		'{30'h1ff9,5'd13},'{30'h15,5'd6},'{30'hf8,5'd8},'{30'h7fa,5'd11},
		'{30'h3fa,5'd10},'{30'h3fb,5'd10},'{30'hf9,5'd8},'{30'h7fb,5'd11},
		'{30'hfa,5'd8},'{30'h16,5'd6},'{30'h17,5'd6},'{30'h18,5'd6},
		'{30'h0,5'd5},'{30'h1,5'd5},'{30'h2,5'd5},'{30'h19,5'd6},
		'{30'h1a,5'd6},'{30'h1b,5'd6},'{30'h1c,5'd6},'{30'h1d,5'd6},
		'{30'h1e,5'd6},'{30'h1f,5'd6},'{30'h5c,5'd7},'{30'hfb,5'd8},
		'{30'h7ffc,5'd15},'{30'h20,5'd6},'{30'hffb,5'd12},'{30'h3fc,5'd10},
		'{30'h1ffa,5'd13},'{30'h21,5'd6},'{30'h5d,5'd7},'{30'h5e,5'd7},
		'{30'h5f,5'd7},'{30'h60,5'd7},'{30'h61,5'd7},'{30'h62,5'd7},
		'{30'h63,5'd7},'{30'h64,5'd7},'{30'h65,5'd7},'{30'h66,5'd7},
		'{30'h67,5'd7},'{30'h68,5'd7},'{30'h69,5'd7},'{30'h6a,5'd7},
		'{30'h6b,5'd7},'{30'h6c,5'd7},'{30'h6d,5'd7},'{30'h6e,5'd7},
		'{30'h6f,5'd7},'{30'h70,5'd7},'{30'h71,5'd7},'{30'h72,5'd7},
		'{30'hfc,5'd8},'{30'h73,5'd7},'{30'hfd,5'd8},'{30'h1ffb,5'd13},
		'{30'h7fff0,5'd19},'{30'h1ffc,5'd13},'{30'h3ffc,5'd14},'{30'h22,5'd6},
		'{30'h7ffd,5'd15},'{30'h3,5'd5},'{30'h23,5'd6},'{30'h4,5'd5},
		'{30'h24,5'd6},'{30'h5,5'd5},'{30'h25,5'd6},'{30'h26,5'd6},
		'{30'h27,5'd6},'{30'h6,5'd5},'{30'h74,5'd7},'{30'h75,5'd7},
		'{30'h28,5'd6},'{30'h29,5'd6},'{30'h2a,5'd6},'{30'h7,5'd5},
		'{30'h2b,5'd6},'{30'h76,5'd7},'{30'h2c,5'd6},'{30'h8,5'd5},
		'{30'h9,5'd5},'{30'h2d,5'd6},'{30'h77,5'd7},'{30'h78,5'd7},
		'{30'h79,5'd7},'{30'h7a,5'd7},'{30'h7b,5'd7},'{30'h7ffe,5'd15},
		'{30'h7fc,5'd11},'{30'h3ffd,5'd14},'{30'h1ffd,5'd13},'{30'hffffffc,5'd28},
		'{30'hfffe6,5'd20},'{30'h3fffd2,5'd22},'{30'hfffe7,5'd20},'{30'hfffe8,5'd20},
		'{30'h3fffd3,5'd22},'{30'h3fffd4,5'd22},'{30'h3fffd5,5'd22},'{30'h7fffd9,5'd23},
		'{30'h3fffd6,5'd22},'{30'h7fffda,5'd23},'{30'h7fffdb,5'd23},'{30'h7fffdc,5'd23},
		'{30'h7fffdd,5'd23},'{30'h7fffde,5'd23},'{30'hffffeb,5'd24},'{30'h7fffdf,5'd23},
		'{30'hffffec,5'd24},'{30'hffffed,5'd24},'{30'h3fffd7,5'd22},'{30'h7fffe0,5'd23},
		'{30'hffffee,5'd24},'{30'h7fffe1,5'd23},'{30'h7fffe2,5'd23},'{30'h7fffe3,5'd23},
		'{30'h7fffe4,5'd23},'{30'h1fffdc,5'd21},'{30'h3fffd8,5'd22},'{30'h7fffe5,5'd23},
		'{30'h3fffd9,5'd22},'{30'h7fffe6,5'd23},'{30'h7fffe7,5'd23},'{30'hffffef,5'd24},
		'{30'h3fffda,5'd22},'{30'h1fffdd,5'd21},'{30'hfffe9,5'd20},'{30'h3fffdb,5'd22},
		'{30'h3fffdc,5'd22},'{30'h7fffe8,5'd23},'{30'h7fffe9,5'd23},'{30'h1fffde,5'd21},
		'{30'h7fffea,5'd23},'{30'h3fffdd,5'd22},'{30'h3fffde,5'd22},'{30'hfffff0,5'd24},
		'{30'h1fffdf,5'd21},'{30'h3fffdf,5'd22},'{30'h7fffeb,5'd23},'{30'h7fffec,5'd23},
		'{30'h1fffe0,5'd21},'{30'h1fffe1,5'd21},'{30'h3fffe0,5'd22},'{30'h1fffe2,5'd21},
		'{30'h7fffed,5'd23},'{30'h3fffe1,5'd22},'{30'h7fffee,5'd23},'{30'h7fffef,5'd23},
		'{30'hfffea,5'd20},'{30'h3fffe2,5'd22},'{30'h3fffe3,5'd22},'{30'h3fffe4,5'd22},
		'{30'h7ffff0,5'd23},'{30'h3fffe5,5'd22},'{30'h3fffe6,5'd22},'{30'h7ffff1,5'd23},
		'{30'h3ffffe0,5'd26},'{30'h3ffffe1,5'd26},'{30'hfffeb,5'd20},'{30'h7fff1,5'd19},
		'{30'h3fffe7,5'd22},'{30'h7ffff2,5'd23},'{30'h3fffe8,5'd22},'{30'h1ffffec,5'd25},
		'{30'h3ffffe2,5'd26},'{30'h3ffffe3,5'd26},'{30'h3ffffe4,5'd26},'{30'h7ffffde,5'd27},
		'{30'h7ffffdf,5'd27},'{30'h3ffffe5,5'd26},'{30'hfffff1,5'd24},'{30'h1ffffed,5'd25},
		'{30'h7fff2,5'd19},'{30'h1fffe3,5'd21},'{30'h3ffffe6,5'd26},'{30'h7ffffe0,5'd27},
		'{30'h7ffffe1,5'd27},'{30'h3ffffe7,5'd26},'{30'h7ffffe2,5'd27},'{30'hfffff2,5'd24},
		'{30'h1fffe4,5'd21},'{30'h1fffe5,5'd21},'{30'h3ffffe8,5'd26},'{30'h3ffffe9,5'd26},
		'{30'hffffffd,5'd28},'{30'h7ffffe3,5'd27},'{30'h7ffffe4,5'd27},'{30'h7ffffe5,5'd27},
		'{30'hfffec,5'd20},'{30'hfffff3,5'd24},'{30'hfffed,5'd20},'{30'h1fffe6,5'd21},
		'{30'h3fffe9,5'd22},'{30'h1fffe7,5'd21},'{30'h1fffe8,5'd21},'{30'h7ffff3,5'd23},
		'{30'h3fffea,5'd22},'{30'h3fffeb,5'd22},'{30'h1ffffee,5'd25},'{30'h1ffffef,5'd25},
		'{30'hfffff4,5'd24},'{30'hfffff5,5'd24},'{30'h3ffffea,5'd26},'{30'h7ffff4,5'd23},
		'{30'h3ffffeb,5'd26},'{30'h7ffffe6,5'd27},'{30'h3ffffec,5'd26},'{30'h3ffffed,5'd26},
		'{30'h7ffffe7,5'd27},'{30'h7ffffe8,5'd27},'{30'h7ffffe9,5'd27},'{30'h7ffffea,5'd27},
		'{30'h7ffffeb,5'd27},'{30'hffffffe,5'd28},'{30'h7ffffec,5'd27},'{30'h7ffffed,5'd27},
		'{30'h7ffffee,5'd27},'{30'h7ffffef,5'd27},'{30'h7fffff0,5'd27},'{30'h3ffffee,5'd26}
	};

	// Child entry: zero is no child, bit 8 set is a leaf carrying the symbol,
	// otherwise the index of the next internal node.
	function automatic tree_t build_tree();
		tree_t       t;
		int          used;
		int          node;
		int          b;
		int          s;
		logic        done;
		logic        dir;
		logic [8:0]  c;
		t    = '0;
		used = 1;
		for (s = 0; s < 256; s++) begin
			node = 0;
			done = 1'b0;
			for (b = 30; b > 1; b--) begin
				if (!done && b <= int'(CODES[s].len)) begin
					dir = CODES[s].pat[b-1];
					c   = t[node][dir];
					if (c == 9'd0) begin
						if (used >= 256) begin
							done = 1'b1;
						end else begin
							c    = 9'(used);
							used = used + 1;
							t[node][dir] = c;
						end
					end
					if (!done && c[8]) begin
						done = 1'b1;
					end
					if (!done) begin
						node = int'(c[7:0]);
					end
				end
			end
			if (!done) begin
				t[node][CODES[s].pat[0]] = {1'b1, 8'(s)};
			end
		end
		return t;
	endfunction

	localparam tree_t TREE = build_tree();

endpackage

// ===== sv/hpack_huffman_decoder.sv =====
// Each request is accepted in idle, then takes eight tree steps (one bit per cycle
// through the decode table while no stall holds the walk), then flushes the held result.
// A new request is taken only once the decoder is back in idle.
// Results leave through an output register, up to three per request.
// Asynchronous active-low reset returns the walk to the root and clears the failure flag.
module hpack_huffman_decoder
	import hhd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_t;

	state_t     state_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [2:0] bitcnt_q;
	logic [7:0] pos_q;
	logic       failed_q;
	logic       pend_vld_q;
	out_t       pend_q;
	logic       out_vld_q;
	out_t       out_q;

	logic [8:0] child;
	logic       produce;
	out_t       res;
	logic       out_free;
	logic       stall;
	logic       load_out;
	out_t       load_val;

	assign child    = TREE[pos_q][byte_q[7]];
	assign out_free = !out_vld_q || out_ready;

	always_comb begin
		produce  = 1'b0;
		res      = '{kind: KIND_SYM, symbol: 8'd0, last_of_run: 1'b0};
		load_out = 1'b0;
		load_val = pend_q;
		unique case (state_q)
			ST_WALK: begin
				if (!failed_q) begin
					if (child == 9'd0) begin
						produce  = 1'b1;
						res.kind = KIND_ERR;
					end else if (child[8]) begin
						produce    = 1'b1;
						res.symbol = child[7:0];
					end
				end
			end
			ST_FLUSH: begin
				if (last_q) begin
					produce  = 1'b1;
					res.kind = KIND_END;
				end else begin
					load_val.last_of_run = 1'b1;
				end
			end
			default: begin
			end
		endcase
		stall = produce && pend_vld_q && !out_free;
		if (state_q != ST_IDLE && pend_vld_q && out_free) begin
			load_out = produce || state_q == ST_FLUSH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= 8'd0;
			failed_q   <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			last_q     <= 1'b0;
			bitcnt_q   <= 3'd0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
				out_q     <= load_val;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						byte_q   <= in_data.code_byte;
						last_q   <= in_data.last_in_string;
						bitcnt_q <= 3'd0;
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!stall) begin
						byte_q   <= {byte_q[6:0], 1'b0};
						bitcnt_q <= bitcnt_q + 3'd1;
						if (produce) begin
							pend_q     <= res;
							pend_vld_q <= 1'b1;
							pos_q      <= 8'd0;
							if (res.kind == KIND_ERR) begin
								failed_q <= 1'b1;
							end
						end else if (load_out) begin
							pend_vld_q <= 1'b0;
						end
						if (!produce && !failed_q) begin
							pos_q <= child[7:0];
						end
						if (bitcnt_q == 3'd7) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (produce) begin
						if (!stall) begin
							pend_q     <= res;
							pend_vld_q <= 1'b1;
							last_q     <= 1'b0;
							pos_q      <= 8'd0;
							failed_q   <= 1'b0;
						end
					end else if (pend_vld_q) begin
						if (out_free) begin
							pend_vld_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// ===== sv/hhd_checker.sv =====
`include "hpack_huffman_decoder_assert.svh"

module hhd_checker
	import hhd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	`HHD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`HHD_ASSERT_NOW(a_sym_zero, out_valid && out_data.kind != KIND_SYM, out_data.symbol == 8'd0)
	`HHD_ASSERT_NOW(a_end_last, out_valid && out_data.kind == KIND_END, out_data.last_of_run)
	`HHD_ASSERT_NEXT(a_one_at_time, in_valid && in_ready, !in_ready)

endmodule

bind hpack_huffman_decoder hhd_checker u_hhd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== dv/testbench.sv =====
module testbench
	import hhd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	class decode_scoreboard;
		logic [8:0] walk_tree [256][2];
		logic [7:0] walk_node;
		bit         walk_failed;
		out_t       pending [$];
		int         errors;
		int         seen [3];

		function new();
			int         used;
			int         node;
			int         s;
			int         b;
			logic [8:0] c;
			for (int i = 0; i < 256; i++) begin
				walk_tree[i][0] = '0;
				walk_tree[i][1] = '0;
			end
			used = 1;
			for (s = 0; s < 256; s++) begin
				node = 0;
				for (b = int'(CODES[s].len) - 1; b >= 1; b--) begin
					c = walk_tree[node][CODES[s].pat[b]];
					if (c == '0) begin
						c = 9'(used);
						used++;
						walk_tree[node][CODES[s].pat[b]] = c;
					end
					node = int'(c[7:0]);
				end
				walk_tree[node][CODES[s].pat[0]] = {1'b1, 8'(s)};
			end
			walk_node   = '0;
			walk_failed = 1'b0;
			errors      = 0;
		endfunction

		function void add_expected(out_t r);
			pending.insert(pending.size(), r);
		endfunction

		function void note_request(in_t req);
			out_t       r;
			logic [8:0] c;
			int         n;
			n = 0;
			for (int b = 7; b >= 0 && !walk_failed; b--) begin
				c = walk_tree[walk_node][req.code_byte[b]];
				r = '0;
				if (c == '0) begin
					r.kind = KIND_ERR;
					walk_failed = 1'b1;
					walk_node = '0;
					add_expected(r);
					n++;
				end else if (c[8]) begin
					r.kind = KIND_SYM;
					r.symbol = c[7:0];
					walk_node = '0;
					add_expected(r);
					n++;
				end else begin
					walk_node = c[7:0];
				end
			end
			if (req.last_in_string) begin
				r = '0;
				r.kind = KIND_END;
				add_expected(r);
				n++;
				walk_node = '0;
				walk_failed = 1'b0;
			end
			if (n > 0) pending[$].last_of_run = 1'b1;
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (pending.size() == 0) begin
				$error("unexpected result kind=%0d symbol=%0d", got.kind, got.symbol);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.symbol !== want.symbol) begin
				$error("symbol: expected %0d, got %0d", want.symbol, got.symbol);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0d, got %0d", want.last_of_run,
					got.last_of_run);
				errors++;
			end
			if (want.kind <= KIND_END) seen[want.kind]++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	decode_scoreboard board;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;
	int  quiet_cycles;
	int  requests_sent;

	hpack_huffman_decoder u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
		if (hold_req) begin
			out_ready <= 1'b0;
			repeat (400) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= 3000) begin
			$display("timeout: no handshake for %0d cycles", quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		int idle;
		in_t req;
		idle = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		req.code_byte = b;
		req.last_in_string = last;
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		board.note_request(req);
		requests_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Builds a coded string from random symbols, sometimes with an end-of-string
	// code or garbage padding slipped in, and sends it byte by byte.
	task automatic send_string();
		bit  bits [$];
		int  nsym;
		int  s;
		int  pad;
		logic [7:0] b;
		nsym = $urandom_range(8, 1);
		for (int i = 0; i < nsym; i++) begin
			if ($urandom_range(9) < 7) s = $urandom_range(32, 126);
			else s = $urandom_range(255);
			for (int k = int'(CODES[s].len) - 1; k >= 0; k--)
				bits.insert(bits.size(), CODES[s].pat[k]);
			if ($urandom_range(29) == 0)
				for (int k = 0; k < 30; k++) bits.insert(bits.size(), 1'b1);
		end
		pad = (8 - bits.size() % 8) % 8;
		for (int k = 0; k < pad; k++)
			bits.insert(bits.size(), ($urandom_range(9) == 0) ? 1'($urandom) : 1'b1);
		while (bits.size() > 0) begin
			for (int k = 7; k >= 0; k--) b[k] = bits.pop_front();
			send_byte(b, bits.size() == 0);
		end
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int target, bit squeeze);
		bit held;
		held           = 1'b0;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		target += requests_sent;
		while (requests_sent < target) begin
			if (squeeze && !held && requests_sent + 40 >= target) begin
				hold_req = 1'b1;
				held     = 1'b1;
			end
			if ($urandom_range(9) < 8) send_string();
			else send_byte(8'($urandom), 1'($urandom_range(3) == 0));
		end
		wait_drained();
	endtask

	initial begin
		board          = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		hold_req       = 1'b0;
		quiet_cycles   = 0;
		requests_sent  = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three zero codes, one split across bytes, then the end of string code, a failed
		// string with ignored bytes, a long code and trailing partial bits.
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hfc, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hf0, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b1);
		send_byte(8'h1f, 1'b1);
		send_byte(8'hfe, 1'b0);
		send_byte(8'h3f, 1'b1);
		wait_drained();

		run_phase(12, 67, 84, 1'b0);
		run_phase(67, 12, 84, 1'b0);
		run_phase(0, 0, 84, 1'b1);

		$display("Sent %0d coded bytes; checked %0d symbols, %0d invalid codes, %0d string ends.",
			requests_sent, board.seen[0], board.seen[1], board.seen[2]);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
